[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL modules of the cellular noise shader.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CNS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define CNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/cns_pkg.sv]
// Package of the cellular noise shader: payload structs, command and status
// structs between controller and datapath, and shared constants. No dependencies.
package cns_pkg;

    localparam int COORD_BITS  = 14;
    localparam int MAX_CENTERS = 256;
    localparam int ADDR_BITS   = 8;
    localparam int CNT_BITS    = 9;
    localparam int DIST_BITS   = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS   = 23;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int PROD_BITS   = 47;
    localparam int NUM_BITS    = PROD_BITS + 9;
    localparam int SUM_BITS    = 24;
    localparam int ITER_BITS   = 6;
    localparam int POS_BITS    = 25;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_PIXEL = 1'b1;

    localparam logic [2:0] REG_LOG2_WIDTH   = 3'd0;
    localparam logic [2:0] REG_LOG2_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CENTER_COUNT = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
    localparam logic [2:0] REG_OUTER_MODE   = 3'd4;

    typedef struct packed {
        logic [0:0]  operation;
        logic [7:0]  center_slot;
        logic [13:0] center_x;
        logic [13:0] center_y;
        logic [13:0] pixel_col;
        logic [13:0] pixel_row;
    } in_t;

    typedef struct packed {
        logic [24:0] gradient_pos;
        logic [7:0]  nearest_cell;
    } out_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic sqrt_init;
        logic sqrt_sel;
        logic sqrt_step;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic all_issued;
        logic pipe_busy;
        logic iter_zero;
        logic out_free;
        logic outer;
    } sts_t;

endpackage

[hw/rtl/cns_ctrl.sv]
// Controller of the cellular noise shader: sequences scan, square roots,
// multiply and divide. Depends on cns_pkg.
module cns_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [0:0]       in_op,
    output logic             in_ready,
    input  cns_pkg::sts_t    sts,
    output cns_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_SQRT0 = 4'd2;
    localparam logic [3:0] ST_SQRT1 = 4'd3;
    localparam logic [3:0] ST_MUL0  = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_DIVI  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_SQRTI = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_op == cns_pkg::OP_LOAD))
                begin
                    cmd.load = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = !sts.all_issued;
                if (sts.all_issued && !sts.pipe_busy)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT0;
                end
            end
            ST_SQRT0:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.iter_zero)
                begin
                    if (sts.outer)
                    begin
                        state_next = ST_SQRTI;
                    end
                    else
                    begin
                        state_next = ST_MUL0;
                    end
                end
            end
            // The second root is loaded once the first one has been stored.
            ST_SQRTI:
            begin
                cmd.sqrt_init = 1'b1;
                cmd.sqrt_sel  = 1'b1;
                state_next    = ST_SQRT1;
            end
            ST_SQRT1:
            begin
                cmd.sqrt_sel  = 1'b1;
                cmd.sqrt_step = 1'b1;
                if (sts.iter_zero)
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_hi = 1'b1;
                state_next = sts.outer ? ST_DIVI : ST_FIN;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.iter_zero)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/cns_datapath.sv]
// Datapath of the cellular noise shader: configuration, center table, distance
// pipeline, root, multiply and divide units, output register. Depends on cns_pkg.
`include "assert_macros.svh"

module cns_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_wdata,
    input  cns_pkg::in_t     in_data,
    input  cns_pkg::cmd_t    cmd,
    output cns_pkg::sts_t    sts,
    output logic             out_valid,
    input  logic             out_ready,
    output cns_pkg::out_t    out_data
);

    localparam int CB = cns_pkg::COORD_BITS;

    logic [3:0]  lw_reg, lh_reg;
    logic [8:0]  count_reg;
    logic [23:0] amp_reg;
    logic        outer_reg;

    logic [2*CB-1:0] mem [cns_pkg::MAX_CENTERS];

    logic [CB-1:0]   sx_reg, sy_reg;
    logic [cns_pkg::CNT_BITS-1:0] cnt_reg;
    logic [cns_pkg::CNT_BITS-1:0] n_lim;
    logic            rd_vld_reg, dist_vld_reg;
    logic [2*CB-1:0] rd_data_reg;
    logic [cns_pkg::ADDR_BITS-1:0] rd_idx_reg, dist_idx_reg, besti_reg;
    logic [cns_pkg::DIST_BITS-1:0] dist_reg, best_reg, best2_reg;

    logic [cns_pkg::RAD_BITS-1:0]  rad_reg;
    logic [cns_pkg::ROOT_BITS+1:0] srem_reg;
    logic [cns_pkg::ROOT_BITS-1:0] root_reg, r0_reg, r1_reg;
    logic [cns_pkg::ITER_BITS-1:0] iter_reg;
    logic [cns_pkg::PROD_BITS-1:0] prod_reg;
    logic [cns_pkg::NUM_BITS-1:0]  num_reg, quot_reg;
    logic [cns_pkg::SUM_BITS-1:0]  sum_reg, drem_reg;

    logic    out_valid_reg;
    cns_pkg::out_t out_reg;

    // Sample position along one axis: half step plus index times step, wrapped.
    function automatic logic [CB-1:0] sample_pos(input logic [CB-1:0] idx,
                                                 input logic [3:0] lg);
        logic [3:0]    s;
        logic [3:0]    sh;
        logic [CB-1:0] half;
        s    = (lg > 4'(CB)) ? 4'(CB) : lg;
        sh   = 4'(CB) - s;
        half = (sh == 4'd0) ? '0 : (CB'(1) << (sh - 4'd1));
        return (idx << sh) + half;
    endfunction

    // Wrapped squared distance along one axis.
    function automatic logic [2*CB-1:0] axis_sq(input logic [CB-1:0] a,
                                                input logic [CB-1:0] b);
        logic [CB-1:0] d;
        logic [CB:0]   e;
        logic [CB-1:0] m;
        d = a - b;
        e = (CB+1)'(1 << CB) - {1'b0, d};
        m = ({1'b0, d} < e) ? d : e[CB-1:0];
        return (2*CB)'(m) * (2*CB)'(m);
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg    <= 4'd8;
            lh_reg    <= 4'd8;
            count_reg <= 9'd1;
            amp_reg   <= 24'd65536;
            outer_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cns_pkg::REG_LOG2_WIDTH:   lw_reg    <= cfg_wdata[3:0];
                cns_pkg::REG_LOG2_HEIGHT:  lh_reg    <= cfg_wdata[3:0];
                cns_pkg::REG_CENTER_COUNT: count_reg <= cfg_wdata[8:0];
                cns_pkg::REG_AMPLITUDE:    amp_reg   <= cfg_wdata;
                cns_pkg::REG_OUTER_MODE:   outer_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Center table: written by load transactions, read one entry per scan cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[in_data.center_slot] <= {in_data.center_x, in_data.center_y};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_data_reg <= mem[cnt_reg[cns_pkg::ADDR_BITS-1:0]];
        end
    end

    assign n_lim = (count_reg == '0) ? 9'd1
                 : (count_reg > 9'(cns_pkg::MAX_CENTERS)) ? 9'(cns_pkg::MAX_CENTERS)
                 : count_reg;

    // Scan pipeline: read, distance, nearest and second nearest update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            dist_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + 9'd1;
            end
            rd_vld_reg   <= cmd.scan;
            dist_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sx_reg    <= sample_pos(in_data.pixel_col, lw_reg);
            sy_reg    <= sample_pos(in_data.pixel_row, lh_reg);
            best_reg  <= cns_pkg::DIST_BITS'(1) << (2 * CB);
            best2_reg <= cns_pkg::DIST_BITS'(1) << (2 * CB);
            besti_reg <= '0;
        end
        else if (dist_vld_reg)
        begin
            if (dist_reg < best_reg)
            begin
                best2_reg <= best_reg;
                best_reg  <= dist_reg;
                besti_reg <= dist_idx_reg;
            end
            else if ((dist_reg > best_reg) && (dist_reg < best2_reg))
            begin
                best2_reg <= dist_reg;
            end
        end
        rd_idx_reg   <= cnt_reg[cns_pkg::ADDR_BITS-1:0];
        dist_idx_reg <= rd_idx_reg;
        dist_reg     <= cns_pkg::DIST_BITS'(axis_sq(sx_reg, rd_data_reg[2*CB-1:CB]))
                      + cns_pkg::DIST_BITS'(axis_sq(sy_reg, rd_data_reg[CB-1:0]));
    end

    // Iteration counter shared by the root and divide units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.sqrt_init)
        begin
            iter_reg <= 6'(cns_pkg::ROOT_BITS - 1);
        end
        else if (cmd.div_init)
        begin
            iter_reg <= 6'(cns_pkg::NUM_BITS - 1);
        end
        else if (cmd.sqrt_step || cmd.div_step)
        begin
            iter_reg <= iter_reg - 6'd1;
        end
    end

    // Digit-by-digit square root, one result bit per cycle.
    logic [cns_pkg::ROOT_BITS+3:0] rem_sh, trial;
    logic                          sq_ge;
    logic [cns_pkg::ROOT_BITS-1:0] root_next;
    assign rem_sh    = {srem_reg, rad_reg[cns_pkg::RAD_BITS-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (rem_sh >= trial);
    assign root_next = {root_reg[cns_pkg::ROOT_BITS-2:0], sq_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg  <= cns_pkg::RAD_BITS'({cmd.sqrt_sel ? best2_reg : best_reg, 16'h0000});
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= rad_reg << 2;
            srem_reg <= sq_ge ? (cns_pkg::ROOT_BITS+2)'(rem_sh - trial)
                              : (cns_pkg::ROOT_BITS+2)'(rem_sh);
            root_reg <= root_next;
            if (iter_reg == '0)
            begin
                if (cmd.sqrt_sel)
                begin
                    r1_reg <= root_next;
                end
                else
                begin
                    r0_reg <= root_next;
                end
            end
        end
    end

    // Root times amplitude in two halves of the amplitude.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            prod_reg <= cns_pkg::PROD_BITS'(r0_reg) * cns_pkg::PROD_BITS'(amp_reg[11:0]);
        end
        else if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + ((cns_pkg::PROD_BITS'(r0_reg)
                                     * cns_pkg::PROD_BITS'(amp_reg[23:12])) << 12);
        end
    end

    // Restoring division for the ratio, one quotient bit per cycle.
    logic [cns_pkg::SUM_BITS:0] drs;
    logic                       dv_ge;
    assign drs   = {drem_reg, num_reg[cns_pkg::NUM_BITS-1]};
    assign dv_ge = (drs >= {1'b0, sum_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_reg  <= {prod_reg, 9'h000};
            sum_reg  <= cns_pkg::SUM_BITS'(r0_reg) + cns_pkg::SUM_BITS'(r1_reg);
            drem_reg <= '0;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= num_reg << 1;
            drem_reg <= dv_ge ? cns_pkg::SUM_BITS'(drs - {1'b0, sum_reg})
                              : cns_pkg::SUM_BITS'(drs);
            quot_reg <= {quot_reg[cns_pkg::NUM_BITS-2:0], dv_ge};
        end
    end

    // Final value with clamping to the end of the gradient.
    logic [cns_pkg::NUM_BITS-1:0] t_raw;
    logic [cns_pkg::POS_BITS-1:0] t_clamp;
    always_comb
    begin
        if (outer_reg)
        begin
            t_raw = (sum_reg == '0) ? '0 : quot_reg;
        end
        else
        begin
            t_raw = cns_pkg::NUM_BITS'(prod_reg >> CB);
        end
        t_clamp = (t_raw > cns_pkg::NUM_BITS'(1 << 24)) ? 25'(1 << 24) : t_raw[24:0];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.gradient_pos <= t_clamp;
            out_reg.nearest_cell <= besti_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sts.all_issued = (cnt_reg == n_lim);
    assign sts.pipe_busy  = rd_vld_reg || dist_vld_reg;
    assign sts.iter_zero  = (iter_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.outer      = outer_reg;

    // A result is never loaded over one that is still waiting.
    `CNS_ASSERT_IMPL(a_no_overwrite, cmd.finish, !(out_valid_reg && !out_ready))
    // A table read always follows an advance of the scan counter.
    `CNS_ASSERT_IMPL(a_read_counted, rd_vld_reg, cnt_reg != '0)
    // The scan never runs past the searched count.
    `CNS_ASSERT_NEXT(a_scan_bound, cmd.scan, cnt_reg <= n_lim)

endmodule

[hw/rtl/cellular_noise_shader_core.sv]
// Top level of the cellular noise shader: ties controller and datapath.
// Depends on cns_pkg, cns_ctrl and cns_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | in_valid / in_ready  | in_data (cns_pkg::in_t)
//   output   | out_valid / out_ready| out_data (cns_pkg::out_t)
//   config   | cfg_we               | cfg_index, cfg_wdata
//
// A load transaction writes one center table entry and leaves the controller idle.
// A pixel transaction runs the one-entry-per-cycle table scan over the n searched
// centers, the bit-serial root unit, the multiply and, in outer mode, the divider.
// Reset idles control and restores configuration defaults, not the center table.
// A waiting result stalls only the final step of the next pixel.
module cellular_noise_shader_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_wdata,
    input  logic           in_valid,
    output logic           in_ready,
    input  cns_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cns_pkg::out_t  out_data
);

    cns_pkg::cmd_t cmd;
    cns_pkg::sts_t sts;

    // Sequencer.
    cns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.operation),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    cns_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
